// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent assertion that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLKD(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- design/plist_pkg.sv -----
package plist_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_cmd_beat;

    typedef struct packed {
        t_status            status;
        logic [4:0]         element_count;
        logic signed [31:0] element_value;
        logic               element_valid;
        logic               last_result;
    } t_result_beat;

endpackage

// ----- design/positional_list_engine.sv -----
// Ordered list of up to CAPACITY signed values, held in a row of cells.
// Command channel: a beat on i_cmd is taken at a rising edge where start is
// high and busy is low. Result channel: o_result is valid for exactly one
// cycle while o_strobe is high; the receiver cannot stall it.
// Insert and delete commands reshape the whole row in the accept cycle and
// give one result beat in the next cycle, so they sustain one command per
// cycle.
// A dump holds busy high after the accept while the row rotates one place
// per cycle past its head cell until every element has passed it once; the
// beats follow one per cycle, each registered from the head cell, the last
// one marked by last_result. The next command can be taken at the edge that
// ends the last beat.
// The row is back in its original order when the dump ends.
// A dump of an empty list and any failed command give a single beat in the
// cycle after the accept, like any insert or delete.
// Every non-dump beat carries the element count after the command.
// Reset empties the list, clears busy and the strobe; stored values are
// not cleared and are never read before they are written.
module positional_list_engine
    import plist_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_beat    i_cmd,
    output logic         o_strobe,
    output t_result_beat o_result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > 8) ? CW + 1 : 8;

    t_state       r_state;
    t_state       n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    logic          r_strobe;
    logic          n_strobe;
    t_result_beat  r_result;
    t_result_beat  n_result;

    t_cell_op              w_op;
    logic [CW-1:0]         w_idx;
    logic [CW-1:0]         w_last;
    logic [DATA_WIDTH-1:0] w_load;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_dump_go;
    logic [CMPW-1:0]       w_pos;
    logic [CMPW-1:0]       w_cnt;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_last   = CW'(r_count - 1'b1);
    assign w_load   = DATA_WIDTH'(i_cmd.value);
    assign w_pos    = CMPW'(i_cmd.position);
    assign w_cnt    = CMPW'(r_count);
    assign w_dump_go = w_accept && (i_cmd.cmd == CMD_DUMP) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_l;
        logic [DATA_WIDTH-1:0] w_r;
        if (g == 0) begin : g_first
            assign w_l = w_data[g];
        end else begin : g_mid_l
            assign w_l = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_r = w_data[g];
        end else begin : g_mid_r
            assign w_r = w_data[g+1];
        end
        plist_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .CNT_W     (CW),
            .POS       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_idx  (w_idx),
            .i_last (w_last),
            .i_load (w_load),
            .i_left (w_l),
            .i_right(w_r),
            .i_head (w_data[0]),
            .o_data (w_data[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_dump_go) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (r_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        busy = (r_state == ST_DUMP);
    end

    always_comb begin
        t_status st;
        st       = STAT_OK;
        w_op     = CELL_HOLD;
        w_idx    = '0;
        n_count  = r_count;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_result = r_result;
        if (r_state == ST_DUMP) begin
            w_op     = CELL_ROTATE;
            n_left   = CW'(r_left - 1'b1);
            n_strobe = 1'b1;
            n_result.status        = STAT_OK;
            n_result.element_count = 5'(r_count);
            n_result.element_value = 32'(w_data[0]);
            n_result.element_valid = 1'b1;
            n_result.last_result   = (r_left == CW'(1));
        end else if (w_accept) begin
            unique case (i_cmd.cmd)
                CMD_INS_FRONT, CMD_INS_BACK: begin
                    if (w_full) begin
                        st = STAT_FULL;
                    end else begin
                        w_op    = CELL_INSERT;
                        w_idx   = (i_cmd.cmd == CMD_INS_FRONT) ? '0 : r_count;
                        n_count = CW'(r_count + 1'b1);
                    end
                end
                CMD_INS_AT: begin
                    if (w_pos == '0 || w_pos > w_cnt + 1'b1) begin
                        st = STAT_BADPOS;
                    end else if (w_full) begin
                        st = STAT_FULL;
                    end else begin
                        w_op    = CELL_INSERT;
                        w_idx   = CW'(w_pos - 1'b1);
                        n_count = CW'(r_count + 1'b1);
                    end
                end
                CMD_DEL_FRONT, CMD_DEL_BACK: begin
                    if (w_empty) begin
                        st = STAT_EMPTY;
                    end else begin
                        w_op    = CELL_DELETE;
                        w_idx   = (i_cmd.cmd == CMD_DEL_FRONT) ? '0 : w_last;
                        n_count = w_last;
                    end
                end
                CMD_DEL_AT: begin
                    if (w_empty) begin
                        st = STAT_EMPTY;
                    end else if (w_pos == '0 || w_pos > w_cnt) begin
                        st = STAT_BADPOS;
                    end else begin
                        w_op    = CELL_DELETE;
                        w_idx   = CW'(w_pos - 1'b1);
                        n_count = w_last;
                    end
                end
                CMD_DUMP: begin
                    n_left = r_count;
                    if (w_empty) begin
                        st = STAT_EMPTY;
                    end
                end
                default: begin
                    st = STAT_OK;
                end
            endcase
            if (!w_dump_go) begin
                n_strobe = 1'b1;
                n_result.status        = st;
                n_result.element_count = 5'(n_count);
                n_result.element_value = '0;
                n_result.element_valid = 1'b0;
                n_result.last_result   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- design/plist_cell.sv -----
module plist_cell
    import plist_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int POS        = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CNT_W-1:0]      i_idx,
    input  logic [CNT_W-1:0]      i_last,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_head,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_INSERT: begin
                if (MY_POS > i_idx) begin
                    n_data = i_left;
                end else if (MY_POS == i_idx) begin
                    n_data = i_load;
                end
            end
            CELL_DELETE: begin
                if (MY_POS >= i_idx) begin
                    n_data = i_right;
                end
            end
            CELL_ROTATE: begin
                if (MY_POS == i_last) begin
                    n_data = i_head;
                end else if (MY_POS < i_last) begin
                    n_data = i_right;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- design/plist_checker.sv -----
`include "assert_macros.svh"

module plist_checker
    import plist_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input t_cmd_beat    i_cmd,
    input logic         o_strobe,
    input t_result_beat o_result
);

    logic w_cmd_seen;

    assign w_cmd_seen = (i_cmd.cmd == CMD_DUMP) || (i_cmd.cmd != CMD_DUMP);

    // A result beat is only produced by an accepted command or a running dump.
    `ASSERT_CLKD(a_strobe_cause, i_clk, i_rst_n, o_strobe |-> ($past(start && !busy && w_cmd_seen) || $past(busy)), "result beat without a cause")

    // Dumped elements come out on consecutive cycles until the last one.
    `ASSERT_CLKD(a_dump_gapless, i_clk, i_rst_n, (o_strobe && o_result.element_valid && !o_result.last_result) |=> o_strobe, "gap inside a dump")

    // A failed command gives a single beat that carries no element.
    `ASSERT_NEVER(a_fail_single, i_clk, i_rst_n, o_strobe && (o_result.status != STAT_OK) && (o_result.element_valid || !o_result.last_result), "failed command beat malformed")

    // A beat without an element carries a zero value.
    `ASSERT_NEVER(a_value_zero, i_clk, i_rst_n, o_strobe && !o_result.element_valid && (o_result.element_value != '0), "nonzero value without element")

    // A dump ends with its last element beat in the cycle busy drops.
    `ASSERT_CLKD(a_dump_end, i_clk, i_rst_n, ($fell(busy) && $past(i_rst_n)) |-> (o_strobe && o_result.last_result && o_result.element_valid), "dump ended without last beat")

endmodule

bind positional_list_engine plist_checker u_plist_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_strobe(o_strobe),
    .o_result(o_result)
);
